/* design/csp_inline_policy_check_defines.svh */
// ----------------------------------------------------------------------------
// csp_inline_policy_check_defines.svh
// Assertion macros shared by the inline policy checker modules.
// ----------------------------------------------------------------------------
`ifndef CSP_INLINE_POLICY_CHECK_DEFINES_SVH
`define CSP_INLINE_POLICY_CHECK_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/csp_pkg.sv */
// ----------------------------------------------------------------------------
// csp_pkg
// Types, keyword tables and constants of the inline policy checker.
// ----------------------------------------------------------------------------
package csp_pkg;

	// configuration port
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] ADDR_CHAIN_SELECT = 3'd0;

	// byte classes decided in the front end
	typedef enum logic [1:0] {
		CLS_COMMA = 2'd0,
		CLS_SEMI  = 2'd1,
		CLS_SPACE = 2'd2,
		CLS_CHAR  = 2'd3
	} cls_t;

	// classified item travelling through the queue
	typedef struct packed {
		logic       has;
		logic       last;
		cls_t       cls;
		logic [7:0] lc;
	} item_t;

	// queue depth (power of two, pointers wrap naturally)
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic  vld;
		item_t item;
	} q_port_t;

	// source flag bits
	localparam int unsigned FL_NONCE  = 0;
	localparam int unsigned FL_HASH   = 1;
	localparam int unsigned FL_UNSAFE = 2;
	localparam int unsigned FL_STRICT = 3;

	// directive slots
	localparam int unsigned SLOT_N    = 3;
	localparam int unsigned SLOT_ELEM = 0;
	localparam int unsigned SLOT_BASE = 1;
	localparam int unsigned SLOT_DEF  = 2;

	localparam int unsigned POS_W   = 5;
	localparam logic [POS_W-1:0] POS_MAX = 5'd31;

	// token text, right-aligned in 16 bytes
	localparam int unsigned TXT_W = 8 * 16;
	typedef logic [TXT_W-1:0] txt_t;

	localparam int unsigned KW_N = 6;
	localparam int unsigned KW_NONCE  = 0;
	localparam int unsigned KW_UNSAFE = 4;
	localparam int unsigned KW_STRICT = 5;
	localparam txt_t KW_TEXT [KW_N] = '{
		"'nonce-", "'sha256-", "'sha384-", "'sha512-",
		"'unsafe-inline'", "'strict-dynamic'"
	};
	localparam logic [POS_W-1:0] KW_LEN [KW_N] = '{
		5'd7, 5'd8, 5'd8, 5'd8, 5'd15, 5'd16
	};
	localparam logic [POS_W-1:0] HASH_LEN = 5'd8;
	// nonce and hash keywords match as prefixes
	localparam logic [KW_N-1:0] KW_PREFIX = 6'b001111;
	localparam logic [KW_N-1:0] KW_HASH_MASK = 6'b001110;

	localparam txt_t NAME_TEXT [2][SLOT_N] = '{
		'{"style-src-elem", "style-src", "default-src"},
		'{"script-src-elem", "script-src", "default-src"}
	};
	localparam logic [POS_W-1:0] NAME_LEN [2][SLOT_N] = '{
		'{5'd14, 5'd9, 5'd11},
		'{5'd15, 5'd10, 5'd11}
	};

	// parse context of the back end
	typedef struct packed {
		logic                          pok;
		logic [SLOT_N-1:0]             found;
		logic [SLOT_N-1:0][3:0]        sflags;
		logic [3:0]                    cflags;
		logic                          in_value;
		logic                          started;
		logic [SLOT_N-1:0]             nc;
		logic [KW_N-1:0]               kc;
		logic [POS_W-1:0]              pos;
	} ctx_t;

	localparam ctx_t CTX_INIT = '{
		pok: 1'b1, found: '0, sflags: '0, cflags: '0, in_value: 1'b0,
		started: 1'b0, nc: '1, kc: '1, pos: '0
	};

	// character at position pos of a token of length len (pos < len)
	function automatic logic [7:0] txt_char(txt_t t, logic [POS_W-1:0] len,
			logic [POS_W-1:0] pos);
		logic [POS_W-1:0] off;
		logic [6:0]       base;
		off  = len - pos - 5'd1;
		base = {off[3:0], 3'b000};
		return t[base +: 8];
	endfunction

endpackage

/* design/csp_if.sv */
// ----------------------------------------------------------------------------
// csp_in_if / csp_out_if
// Valid/ready channels of the policy checker: header bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface csp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       carries_byte;
	logic       end_of_string;

	modport source (output valid, output char_byte, output carries_byte,
		output end_of_string, input ready);
	modport sink (input valid, input char_byte, input carries_byte,
		input end_of_string, output ready);
endinterface

interface csp_out_if;
	logic valid;
	logic ready;
	logic inline_allowed;

	modport source (output valid, output inline_allowed, input ready);
	modport sink (input valid, input inline_allowed, output ready);
endinterface

/* design/csp_front.sv */
// ----------------------------------------------------------------------------
// csp_front
// Accepts header bytes, drops empty items, classifies and lower-cases bytes.
// ----------------------------------------------------------------------------
module csp_front import csp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	csp_in_if.sink      pol,
	output q_port_t     wr,
	input  logic        wr_ready
);

	logic  vld_s1;
	item_t item_s1;
	item_t item_c;
	logic  keep;

	// stage is free when empty or draining into the queue this cycle
	assign pol.ready = !vld_s1 || wr_ready;
	// an item with neither byte nor end mark has no effect
	assign keep = pol.carries_byte || pol.end_of_string;

	// classification
	always_comb begin
		item_c.has  = pol.carries_byte;
		item_c.last = pol.end_of_string;
		item_c.lc   = pol.char_byte;
		if (pol.char_byte >= 8'h41 && pol.char_byte <= 8'h5A) begin
			item_c.lc = pol.char_byte + 8'h20;
		end
		if (pol.char_byte == 8'h2C) begin
			item_c.cls = CLS_COMMA;
		end else if (pol.char_byte == 8'h3B) begin
			item_c.cls = CLS_SEMI;
		end else if (pol.char_byte == 8'h20 || pol.char_byte == 8'h09 ||
				pol.char_byte == 8'h0A || pol.char_byte == 8'h0C ||
				pol.char_byte == 8'h0D) begin
			item_c.cls = CLS_SPACE;
		end else begin
			item_c.cls = CLS_CHAR;
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pol.ready) begin
			vld_s1 <= pol.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (pol.ready) begin
			item_s1 <= item_c;
		end
	end

	assign wr.vld  = vld_s1;
	assign wr.item = item_s1;

endmodule

/* design/csp_queue.sv */
// ----------------------------------------------------------------------------
// csp_queue
// Short register queue between the front end and the parser.
// ----------------------------------------------------------------------------
`include "csp_inline_policy_check_defines.svh"

module csp_queue import csp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_port_t wr,
	output logic    wr_ready,
	output q_port_t rd,
	input  logic    rd_pop
);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               push;
	logic               pop;

	assign wr_ready = count_q != Q_CNT_W'(Q_DEPTH);
	assign push     = wr.vld && wr_ready;
	assign pop      = rd_pop && rd.vld;
	assign rd.vld   = count_q != '0;
	assign rd.item  = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.item;
		end
	end

	`CSP_ASSERT_IMP(a_q_bound, clk, arst_n, 1'b1, count_q <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
	`CSP_ASSERT_NXT(a_q_grow, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "queue lost a transfer")
	`CSP_ASSERT_IMP(a_q_pop, clk, arst_n, rd_pop, rd.vld, "pop from empty queue")

endmodule

/* design/csp_back.sv */
// ----------------------------------------------------------------------------
// csp_back
// Policy parser: tracks directive names, source keywords and slot flags per
// classified byte, and produces the verdict at the end of the header.
// ----------------------------------------------------------------------------
`include "csp_inline_policy_check_defines.svh"

module csp_back import csp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       chain_sel,
	input  q_port_t    rd,
	output logic       rd_pop,
	csp_out_if.source  verdict
);

	ctx_t ctx_q;
	ctx_t ctx_d;
	logic out_vld_q;
	logic out_allowed_q;
	logic res_c;
	logic pop;

	// narrow directive name candidates by one character
	function automatic logic [SLOT_N-1:0] narrow_name(logic [SLOT_N-1:0] nc,
			logic [POS_W-1:0] pos, logic sel, logic [7:0] lc);
		logic [SLOT_N-1:0] alive;
		alive = nc;
		for (int i = 0; i < SLOT_N; i++) begin
			if (pos >= NAME_LEN[sel][i]) begin
				alive[i] = 1'b0;
			end else if (txt_char(NAME_TEXT[sel][i], NAME_LEN[sel][i], pos) != lc) begin
				alive[i] = 1'b0;
			end
		end
		return alive;
	endfunction

	// narrow source keyword candidates by one character
	function automatic logic [KW_N-1:0] narrow_kw(logic [KW_N-1:0] kc,
			logic [POS_W-1:0] pos, logic [7:0] lc);
		logic [KW_N-1:0] alive;
		alive = kc;
		for (int i = 0; i < KW_N; i++) begin
			if (pos >= KW_LEN[i]) begin
				if (!KW_PREFIX[i]) begin
					alive[i] = 1'b0;
				end
			end else if (txt_char(KW_TEXT[i], KW_LEN[i], pos) != lc) begin
				alive[i] = 1'b0;
			end
		end
		return alive;
	endfunction

	// close a source token
	function automatic ctx_t finish_token(ctx_t c);
		ctx_t n;
		n = c;
		if (c.kc[KW_NONCE] && c.pos >= KW_LEN[KW_NONCE]) begin
			n.cflags[FL_NONCE] = 1'b1;
		end
		if ((|(c.kc & KW_HASH_MASK)) && c.pos >= HASH_LEN) begin
			n.cflags[FL_HASH] = 1'b1;
		end
		if (c.kc[KW_UNSAFE] && c.pos == KW_LEN[KW_UNSAFE]) begin
			n.cflags[FL_UNSAFE] = 1'b1;
		end
		if (c.kc[KW_STRICT] && c.pos == KW_LEN[KW_STRICT]) begin
			n.cflags[FL_STRICT] = 1'b1;
		end
		n.kc  = '1;
		n.pos = '0;
		return n;
	endfunction

	// close the directive name, keep only full-length matches
	function automatic ctx_t finish_name(ctx_t c, logic sel);
		ctx_t n;
		n = c;
		for (int i = 0; i < SLOT_N; i++) begin
			n.nc[i] = c.nc[i] && (c.pos == NAME_LEN[sel][i]);
		end
		n.in_value = 1'b1;
		n.pos      = '0;
		n.kc       = '1;
		return n;
	endfunction

	// space handling inside a directive
	function automatic ctx_t close_word(ctx_t c, logic sel);
		ctx_t n;
		n = c;
		if (c.in_value) begin
			if (c.pos != '0) begin
				n = finish_token(c);
			end
		end else if (c.started) begin
			n = finish_name(c, sel);
		end
		return n;
	endfunction

	// close a directive; first occurrence of each name fills its slot
	function automatic ctx_t end_directive(ctx_t c, logic sel);
		ctx_t n;
		n = close_word(c, sel);
		if (n.started) begin
			for (int i = 0; i < SLOT_N; i++) begin
				if (n.nc[i] && !n.found[i]) begin
					n.found[i]  = 1'b1;
					n.sflags[i] = n.cflags;
				end
			end
		end
		n.in_value = 1'b0;
		n.started  = 1'b0;
		n.nc       = '1;
		n.kc       = '1;
		n.pos      = '0;
		n.cflags   = '0;
		return n;
	endfunction

	// close a policy: governing slot decides
	function automatic ctx_t end_policy(ctx_t c, logic sel);
		ctx_t       n;
		logic [3:0] f;
		logic       any;
		logic       ok;
		n   = c;
		any = 1'b1;
		if (c.found[SLOT_ELEM]) begin
			f = c.sflags[SLOT_ELEM];
		end else if (c.found[SLOT_BASE]) begin
			f = c.sflags[SLOT_BASE];
		end else if (c.found[SLOT_DEF]) begin
			f = c.sflags[SLOT_DEF];
		end else begin
			f   = '0;
			any = 1'b0;
		end
		ok = f[FL_UNSAFE] && !f[FL_NONCE] && !f[FL_HASH] && !(sel && f[FL_STRICT]);
		if (any && !ok) begin
			n.pok = 1'b0;
		end
		n.found  = '0;
		n.sflags = '0;
		return n;
	endfunction

	// a closing item waits while the verdict register is still held
	assign pop    = rd.vld && (!rd.item.last || !out_vld_q || verdict.ready);
	assign rd_pop = pop;

	// per-byte context update
	always_comb begin
		ctx_t c;
		c     = ctx_q;
		res_c = 1'b0;
		if (pop) begin
			if (rd.item.has) begin
				unique case (rd.item.cls)
					CLS_COMMA: begin
						c = end_directive(c, chain_sel);
						c = end_policy(c, chain_sel);
					end
					CLS_SEMI: begin
						c = end_directive(c, chain_sel);
					end
					CLS_SPACE: begin
						c = close_word(c, chain_sel);
					end
					CLS_CHAR: begin
						if (!c.in_value) begin
							c.started = 1'b1;
							c.nc = narrow_name(c.nc, c.pos, chain_sel, rd.item.lc);
						end else begin
							c.kc = narrow_kw(c.kc, c.pos, rd.item.lc);
						end
						if (c.pos != POS_MAX) begin
							c.pos = c.pos + 1'b1;
						end
					end
					default: begin
						c = ctx_q;
					end
				endcase
			end
			if (rd.item.last) begin
				c     = end_directive(c, chain_sel);
				c     = end_policy(c, chain_sel);
				res_c = c.pok;
				c     = CTX_INIT;
			end
		end
		ctx_d = c;
	end

	// context register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_INIT;
		end else begin
			ctx_q <= ctx_d;
		end
	end

	// verdict output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pop && rd.item.last) begin
			out_vld_q <= 1'b1;
		end else if (verdict.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && rd.item.last) begin
			out_allowed_q <= res_c;
		end
	end

	assign verdict.valid          = out_vld_q;
	assign verdict.inline_allowed = out_allowed_q;

	`CSP_ASSERT_IMP(a_bk_hold, clk, arst_n, out_vld_q && !verdict.ready, !(pop && rd.item.last), "verdict overwritten")
	`CSP_ASSERT_NXT(a_bk_clear, clk, arst_n, pop && rd.item.last, ctx_q == CTX_INIT, "context not cleared after header")
	`CSP_ASSERT_IMP(a_bk_src, clk, arst_n, $rose(out_vld_q), $past(pop && rd.item.last), "verdict without closing item")

endmodule

/* design/csp_inline_policy_check.sv */
// Throughput: one header byte per cycle and one queue entry popped per cycle, unless stalled.
// After the transfer of the closing item, its verdict follows the front stage register,
//   then the queue, then the parser's verdict register.
// A held verdict stalls only closing items; the queue absorbs the front end meanwhile.
// Reset (arst_n low, asynchronous): parser context to its start state, queue empty,
//   no verdict pending, chain_select cleared to the style chain.
// ----------------------------------------------------------------------------
// csp_inline_policy_check
// Streaming check of a security-policy header for honored inline style or script.
// ----------------------------------------------------------------------------
module csp_inline_policy_check import csp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	csp_in_if.sink                pol,
	csp_out_if.source             verdict,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic    chain_sel_q;
	q_port_t wr;
	logic    wr_ready;
	q_port_t rd;
	logic    rd_pop;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_sel_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == ADDR_CHAIN_SELECT) begin
			chain_sel_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_CHAIN_SELECT) begin
			prdata[0] = chain_sel_q;
		end
	end

	csp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pol      (pol),
		.wr       (wr),
		.wr_ready (wr_ready)
	);

	csp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_ready (wr_ready),
		.rd       (rd),
		.rd_pop   (rd_pop)
	);

	csp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.chain_sel (chain_sel_q),
		.rd        (rd),
		.rd_pop    (rd_pop),
		.verdict   (verdict)
	);

endmodule
